// File: hw/rtl/postfix_float_evaluator_core_defines.svh
// Assertion macros for the postfix float evaluator.
// Used by files that check their own logic; expects clk and rst in scope.
`ifndef POSTFIX_FLOAT_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_FLOAT_EVALUATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define PFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pfe assertion failed");
`define PFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfe assertion failed");
`else
`define PFE_ASSERT(lbl, prop)
`define PFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/pfe_pkg.sv
// Shared types and constants of the postfix float evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfe_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_DIV0      = 3'd1;
  localparam logic [2:0] ERR_BADOP     = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] FOP_ADD = 2'd0;
  localparam logic [1:0] FOP_SUB = 2'd1;
  localparam logic [1:0] FOP_MUL = 2'd2;
  localparam logic [1:0] FOP_DIV = 2'd3;

  localparam logic [31:0] FP_QNAN = 32'hFFC0_0000;

  typedef struct packed {
    logic       latch;
    logic       push_digit;
    logic       push_result;
    logic       set_err;
    logic [2:0] err_code;
    logic       rd_lhs;
    logic       cap_rhs;
    logic       cap_lhs;
    logic       pop2;
    logic       fpu_start;
    logic       emit;
  } pfe_cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_digit;
    logic known_op;
    logic op_div;
    logic full;
    logic lt2;
    logic err_set;
    logic rhs_zero;
    logic fpu_done;
    logic out_free;
    logic last;
  } pfe_status_t;

  function automatic logic [31:0] digit_bits(input logic [3:0] d);
    logic [31:0] r;
    case (d)
      4'd0:    r = 32'h0000_0000;
      4'd1:    r = 32'h3F80_0000;
      4'd2:    r = 32'h4000_0000;
      4'd3:    r = 32'h4040_0000;
      4'd4:    r = 32'h4080_0000;
      4'd5:    r = 32'h40A0_0000;
      4'd6:    r = 32'h40C0_0000;
      4'd7:    r = 32'h40E0_0000;
      4'd8:    r = 32'h4100_0000;
      4'd9:    r = 32'h4110_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pfe_fpu.sv
// Multi-cycle single-precision add/sub/mul/div, round to nearest even.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfe_fpu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      res
);
  import pfe_pkg::*;

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_SETUP = 4'd1;
  localparam logic [3:0] F_PRE   = 4'd2;
  localparam logic [3:0] F_ALIGN = 4'd3;
  localparam logic [3:0] F_ADDS  = 4'd4;
  localparam logic [3:0] F_DIV   = 4'd5;
  localparam logic [3:0] F_NORM  = 4'd6;
  localparam logic [3:0] F_ROUND = 4'd7;

  logic [3:0]         state;
  logic [1:0]         fop;
  logic [31:0]        ra, rb;
  logic               sa, sbe, rs, eff_sub;
  logic signed [11:0] ea, eb, re;
  logic [23:0]        ma, mb;
  logic [49:0]        rm;
  logic [25:0]        rem, quot;
  logic [4:0]         qcnt;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
  assign a_nan  = (ra[30:23] == 8'hFF) && (ra[22:0] != 23'd0);
  assign b_nan  = (rb[30:23] == 8'hFF) && (rb[22:0] != 23'd0);
  assign a_inf  = (ra[30:23] == 8'hFF) && (ra[22:0] == 23'd0);
  assign b_inf  = (rb[30:23] == 8'hFF) && (rb[22:0] == 23'd0);
  assign a_zero = (ra[30:0] == 31'd0);
  assign b_zero = (rb[30:0] == 31'd0);
  assign sx     = sa ^ rb[31];

  // alignment for add/sub
  logic        a_big;
  logic [23:0] m_small;
  logic [7:0]  dsh;
  logic [49:0] bx, bmask, b_al;
  always_comb begin
    a_big   = (ea > eb) || ((ea == eb) && (ma >= mb));
    m_small = a_big ? mb : ma;
    dsh     = a_big ? 8'(ea - eb) : 8'(eb - ea);
    bx      = {1'b0, m_small, 25'd0};
    bmask   = ~({50{1'b1}} << dsh);
    b_al    = (bx >> dsh) | {49'd0, |(bx & bmask)};
  end

  logic [49:0] ax, addsum;
  assign ax     = {1'b0, ma, 25'd0};
  assign addsum = eff_sub ? (ax - rm) : (ax + rm);

  logic [47:0] prod;
  assign prod = 48'(ma) * 48'(mb);

  logic        q_bit;
  logic [25:0] rem_diff, rem_next;
  assign q_bit    = rem >= {2'b00, mb};
  assign rem_diff = rem - {2'b00, mb};
  assign rem_next = q_bit ? {rem_diff[24:0], 1'b0} : {rem[24:0], 1'b0};

  // rounding
  logic [23:0]        mant, mant2;
  logic [24:0]        msum;
  logic               rinc;
  logic signed [11:0] e2;
  logic [31:0]        round_res;
  always_comb begin
    mant  = rm[48:25];
    rinc  = rm[24] & ((|rm[23:0]) | mant[0]);
    msum  = {1'b0, mant} + {24'd0, rinc};
    mant2 = msum[24] ? msum[24:1] : msum[23:0];
    e2    = msum[24] ? (re + 12'sd1) : re;
    if (mant2[23] && (e2 >= 12'sd255)) begin
      round_res = {rs, 8'hFF, 23'd0};
    end else if (mant2[23]) begin
      round_res = {rs, e2[7:0], mant2[22:0]};
    end else begin
      round_res = {rs, 8'd0, mant2[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (start) begin
            fop   <= op;
            ra    <= a;
            rb    <= b;
            sa    <= a[31];
            sbe   <= b[31] ^ (op == FOP_SUB);
            ea    <= (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
            eb    <= (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
            ma    <= {a[30:23] != 8'd0, a[22:0]};
            mb    <= {b[30:23] != 8'd0, b[22:0]};
            state <= F_SETUP;
          end
        end
        F_SETUP: begin
          state <= F_IDLE;
          done  <= 1'b1;
          if (a_nan) begin
            res <= ra | 32'h0040_0000;
          end else if (b_nan) begin
            res <= rb | 32'h0040_0000;
          end else begin
            case (fop)
              FOP_ADD, FOP_SUB: begin
                if (a_inf && b_inf && (sa != sbe)) res <= FP_QNAN;
                else if (a_inf) res <= ra;
                else if (b_inf) res <= {sbe, 8'hFF, 23'd0};
                else begin
                  done  <= 1'b0;
                  state <= F_ALIGN;
                end
              end
              FOP_MUL: begin
                if ((a_inf && b_zero) || (b_inf && a_zero)) res <= FP_QNAN;
                else if (a_inf || b_inf) res <= {sx, 8'hFF, 23'd0};
                else if (a_zero || b_zero) res <= {sx, 31'd0};
                else begin
                  done  <= 1'b0;
                  state <= F_PRE;
                end
              end
              default: begin
                if (a_inf && b_inf) res <= FP_QNAN;
                else if (a_inf || b_zero) res <= {sx, 8'hFF, 23'd0};
                else if (b_inf || a_zero) res <= {sx, 31'd0};
                else begin
                  done  <= 1'b0;
                  state <= F_PRE;
                end
              end
            endcase
          end
        end
        F_PRE: begin
          rs <= sx;
          if (!ma[23]) begin
            ma <= {ma[22:0], 1'b0};
            ea <= ea - 12'sd1;
          end else if (!mb[23]) begin
            mb <= {mb[22:0], 1'b0};
            eb <= eb - 12'sd1;
          end else if (fop == FOP_MUL) begin
            rm    <= {prod, 2'b00};
            re    <= ea + eb - 12'sd127;
            state <= F_NORM;
          end else begin
            rem   <= {2'b00, ma};
            qcnt  <= 5'd0;
            re    <= ea - eb + 12'sd127;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          rem  <= rem_next;
          quot <= {quot[24:0], q_bit};
          qcnt <= qcnt + 5'd1;
          if (qcnt == 5'd25) begin
            rm    <= {1'b0, quot[24:0], q_bit, 22'd0, rem_next != 26'd0};
            state <= F_NORM;
          end
        end
        F_ALIGN: begin
          eff_sub <= sa != sbe;
          rs      <= a_big ? sa : sbe;
          if (!a_big) begin
            ma <= mb;
            ea <= eb;
          end
          rm    <= b_al;
          state <= F_ADDS;
        end
        F_ADDS: begin
          rm <= addsum;
          re <= ea;
          if (addsum == 50'd0) rs <= sa & sbe;
          state <= F_NORM;
        end
        F_NORM: begin
          if (rm[49] || (re < 12'sd1)) begin
            rm <= {1'b0, rm[49:2], rm[1] | rm[0]};
            re <= re + 12'sd1;
          end else if (!rm[48] && (re > 12'sd1)) begin
            rm <= {rm[48:0], 1'b0};
            re <= re - 12'sd1;
          end else begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          res   <= round_res;
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pfe_datapath.sv
// Datapath: input latch, operand stack memory, top and error registers,
// floating-point unit and result register. Depends on pfe_pkg, pfe_fpu.
`timescale 1ns / 1ps
`default_nettype none
`include "postfix_float_evaluator_core_defines.svh"
module pfe_datapath #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          char_in,
  input  wire logic                last_in,
  input  wire pfe_pkg::pfe_cmd_t   cmd,
  output pfe_pkg::pfe_status_t     status,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output logic [31:0]              out_value,
  output logic [2:0]               out_err
);
  import pfe_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   rd_data;
  logic [CW-1:0] count;
  logic [2:0]    err;
  logic [7:0]    chr;
  logic          last;
  logic [31:0]   top, rhs, lhs;
  logic [1:0]    fop;
  logic          fpu_done;
  logic [31:0]   fpu_res;
  logic [CW-1:0] rd_off;
  logic [CW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;
  logic [31:0]   digit_val;

  assign digit_val = digit_bits(4'(chr - CH_ZERO));
  assign rd_off    = cmd.rd_lhs ? CW'(2) : CW'(1);
  assign rd_idx    = count - rd_off;
  assign rd_addr   = rd_idx[AW-1:0];

  always_comb begin
    case (chr)
      CH_PLUS:  fop = FOP_ADD;
      CH_MINUS: fop = FOP_SUB;
      CH_STAR:  fop = FOP_MUL;
      default:  fop = FOP_DIV;
    endcase
  end

  always_comb begin
    status.is_space = chr == CH_SPACE;
    status.is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
    status.known_op = (chr == CH_PLUS) || (chr == CH_MINUS) ||
                      (chr == CH_STAR) || (chr == CH_SLASH);
    status.op_div   = chr == CH_SLASH;
    status.full     = count == CW'(STACK_DEPTH);
    status.lt2      = count < CW'(2);
    status.err_set  = err != ERR_OK;
    status.rhs_zero = rhs[30:0] == 31'd0;
    status.fpu_done = fpu_done;
    status.out_free = !m_valid || m_ready;
    status.last     = last;
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (cmd.push_digit) mem[count[AW-1:0]] <= digit_val;
    else if (cmd.push_result) mem[count[AW-1:0]] <= fpu_res;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      chr  <= char_in;
      last <= last_in;
    end
    if (cmd.cap_rhs) rhs <= rd_data;
    if (cmd.cap_lhs) lhs <= rd_data;
    if (cmd.push_digit) top <= digit_val;
    else if (cmd.push_result) top <= fpu_res;
    if (cmd.emit) begin
      out_value <= (err == ERR_OK && count != '0) ? top : 32'd0;
      out_err   <= (err != ERR_OK) ? err :
                   ((count == '0) ? ERR_UNDERFLOW : ERR_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      err     <= ERR_OK;
      m_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        count   <= '0;
        err     <= ERR_OK;
        m_valid <= 1'b1;
      end else begin
        if (m_ready) m_valid <= 1'b0;
        if (cmd.set_err) err <= cmd.err_code;
        if (cmd.push_digit || cmd.push_result) count <= count + CW'(1);
        else if (cmd.pop2) count <= count - CW'(2);
      end
    end
  end

  pfe_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.fpu_start),
    .op    (fop),
    .a     (lhs),
    .b     (rhs),
    .done  (fpu_done),
    .res   (fpu_res)
  );

  `PFE_ASSERT(a_count_bound, count <= CW'(STACK_DEPTH))
  `PFE_ASSERT(a_no_push_on_err, !(cmd.push_digit || cmd.push_result) || (err == ERR_OK))
  `PFE_ASSERT_NEXT(a_emit_clears, cmd.emit, m_valid && (count == '0) && (err == ERR_OK))

endmodule
`default_nettype wire

// File: hw/rtl/pfe_ctrl.sv
// Controller state machine: sequences decode, stack access, FPU and result.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_valid,
  output logic                      s_ready,
  input  wire pfe_pkg::pfe_status_t status,
  output pfe_pkg::pfe_cmd_t         cmd
);
  import pfe_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_RD3  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_EXEC = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0] state, state_next;

  assign s_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.err_code = ERR_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.latch = s_valid;
        if (s_valid) state_next = S_DEC;
      end
      S_DEC: begin
        state_next = S_FIN;
        if (status.err_set || status.is_space) begin
          state_next = S_FIN;
        end else if (status.is_digit) begin
          if (status.full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ERR_OVERFLOW;
          end else begin
            cmd.push_digit = 1'b1;
          end
        end else if (status.lt2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ERR_UNDERFLOW;
        end else begin
          state_next = S_RD1;
        end
      end
      S_RD1: state_next = S_RD2;
      S_RD2: begin
        cmd.cap_rhs = 1'b1;
        cmd.rd_lhs  = 1'b1;
        state_next  = S_RD3;
      end
      S_RD3: begin
        cmd.cap_lhs = 1'b1;
        cmd.pop2    = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        state_next = S_FIN;
        if (!status.known_op) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ERR_BADOP;
        end else if (status.op_div && status.rhs_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ERR_DIV0;
        end else begin
          cmd.fpu_start = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.fpu_done) begin
          cmd.push_result = 1'b1;
          state_next      = S_FIN;
        end
      end
      S_FIN: state_next = status.last ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

// File: hw/rtl/postfix_float_evaluator_core.sv
// Postfix float evaluator: one expression character per request, one result per last char.
// The time from accept to next accept depends on the char kind; FPU operations also depend on
//   the pre/post normalize shifts, which run long when a sum cancels to zero.
// A last char adds an emit step that waits out any output stall; its result is valid as the input turns ready.
// Reset: synchronous rst clears stack count, sticky error, output valid and both FSMs.
`timescale 1ns / 1ps
`default_nettype none
module postfix_float_evaluator_core #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // is_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [31:0] value_bits, [34:32] error_code, rest 0
);
  import pfe_pkg::*;

  pfe_cmd_t    cmd;
  pfe_status_t status;
  logic [31:0] out_value;
  logic [2:0]  out_err;

  // controller: sequences each request through decode, stack reads, FPU
  pfe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // datapath: stack memory, FPU, output register
  pfe_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_in   (s_tdata),
    .last_in   (s_tlast),
    .cmd       (cmd),
    .status    (status),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .out_value (out_value),
    .out_err   (out_err)
  );

  assign m_tdata = {5'd0, out_err, out_value};

endmodule
`default_nettype wire
